[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion macros shared by the RTL
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/i2cm_pkg.sv]
`timescale 1ns / 1ps
package i2cm_pkg;
  localparam int unsigned NREGS = 9;
  localparam logic [3:0] IX_CR1 = 4'd0;
  localparam logic [3:0] IX_CR2 = 4'd1;
  localparam logic [3:0] IX_DR = 4'd4;
  localparam logic [3:0] IX_SR1 = 4'd5;
  localparam logic [3:0] IX_SR2 = 4'd6;
  localparam logic [3:0] IX_TRISE = 4'd8;
  localparam logic [15:0] TRISE_RST = 16'd2;
  localparam logic [15:0] READ_BAD = 16'hFFFF;
  localparam logic [7:0] RX_NONE = 8'hFF;
  localparam int unsigned B_START = 8;
  localparam int unsigned B_STOP = 9;
  localparam int unsigned B_POS = 11;
  localparam logic [15:0] M_SB = 16'h0001;
  localparam logic [15:0] M_ADDR = 16'h0002;
  localparam logic [15:0] M_BTF = 16'h0004;
  localparam logic [15:0] M_RXNE = 16'h0040;
  localparam logic [15:0] M_TXE = 16'h0080;
  localparam logic [15:0] M_AF = 16'h0400;
  localparam logic [15:0] M_ERRS = 16'hDF00;
  localparam logic [15:0] M_EVT = 16'h001F;
  localparam logic [15:0] M_BUF = 16'h00C0;
  localparam logic [15:0] CR2_ERREN = 16'h0100;
  localparam logic [15:0] CR2_EVTEN = 16'h0200;
  localparam logic [15:0] CR2_BUFEN = 16'h0400;

  typedef enum logic [2:0] {
    K_NONE, K_BADRD, K_RDDR, K_RDREG, K_WRCR1, K_WRDR, K_WRREG
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  idx;
    logic [15:0] data;
    logic [7:0]  rx;
    logic        nack;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        event_irq;
    logic        error_irq;
    logic        bus_start;
    logic [6:0]  bus_address;
    logic        bus_direction;
    logic        bus_send;
    logic [7:0]  bus_tx_byte;
    logic        bus_recv;
    logic        bus_stop;
  } res_t;
endpackage

[rtl/i2cm_front.sv]
`timescale 1ns / 1ps
// Classify each access and push it into a two-entry queue.
module i2cm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [29:0]         in_tdata,
  output logic                q_valid,
  input  logic                q_ready,
  output i2cm_pkg::cmd_t      q_cmd
);
  i2cm_pkg::cmd_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rp_r, wp_r;
  logic       push, pop;
  i2cm_pkg::cmd_t c;
  logic       op;

  always_comb begin
    op = in_tdata[0];
    c.idx = in_tdata[4:1];
    c.data = in_tdata[20:5];
    c.rx = in_tdata[28:21];
    c.nack = in_tdata[29];
    if (c.idx > i2cm_pkg::IX_TRISE) c.kind = op ? i2cm_pkg::K_NONE : i2cm_pkg::K_BADRD;
    else if (!op) c.kind = (c.idx == i2cm_pkg::IX_DR) ? i2cm_pkg::K_RDDR : i2cm_pkg::K_RDREG;
    else if (c.idx == i2cm_pkg::IX_CR1) c.kind = i2cm_pkg::K_WRCR1;
    else if (c.idx == i2cm_pkg::IX_DR) c.kind = i2cm_pkg::K_WRDR;
    else c.kind = i2cm_pkg::K_WRREG;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = buf_r[rp_r];
  always_comb cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rp_r <= 1'b0;
      wp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= c;
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_cnt_range, (cnt_r != 2'd3), "queue count out of range")
  `ASSERT_NEXT(a_full_hold, (cnt_r == 2'd2 && !pop), (cnt_r == 2'd2), "full queue lost entry")
  `ASSERT_NEXT(a_empty_hold, (cnt_r == 2'd0 && !push), (cnt_r == 2'd0), "empty queue gained entry")
endmodule

[rtl/i2cm_back.sv]
`timescale 1ns / 1ps
// Execute one access per cycle against the register state while the output is not stalled.
module i2cm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  i2cm_pkg::cmd_t q_cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output i2cm_pkg::res_t out_res
);
  logic [15:0] regs_r [i2cm_pkg::NREGS];
  logic [15:0] regs_nxt [i2cm_pkg::NREGS];
  logic [3:0]  prev_r, prev_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [7:0]  rsh_r, rsh_nxt;
  logic        shb_r, shb_nxt, rdt_r, rdt_nxt, dny_r, dny_nxt, open_r, open_nxt;
  logic        ov_r;
  i2cm_pkg::res_t res_r, res_nxt;
  logic        go;
  logic [7:0]  tb;
  logic [15:0] sr1, cr2;

  assign q_ready = !ov_r || out_tready;
  assign go = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_res = res_r;

  always_comb begin
    for (int i = 0; i < i2cm_pkg::NREGS; i++) regs_nxt[i] = regs_r[i];
    prev_nxt = prev_r; tgt_nxt = tgt_r; rsh_nxt = rsh_r; shb_nxt = shb_r;
    rdt_nxt = rdt_r; dny_nxt = dny_r; open_nxt = open_r;
    res_nxt = '0;
    tb = open_r ? q_cmd.rx : i2cm_pkg::RX_NONE;
    case (q_cmd.kind)
      i2cm_pkg::K_BADRD: res_nxt.read_data = i2cm_pkg::READ_BAD;
      i2cm_pkg::K_RDDR: begin
        if ((regs_r[i2cm_pkg::IX_SR1] & i2cm_pkg::M_RXNE) != 16'd0) begin
          if (open_r) begin
            if (!dny_r) begin
              regs_nxt[i2cm_pkg::IX_DR] = {8'd0, rsh_r};
              rsh_nxt = tb; res_nxt.bus_recv = 1'b1;
              regs_nxt[i2cm_pkg::IX_SR1] = regs_r[i2cm_pkg::IX_SR1] | i2cm_pkg::M_BTF;
              shb_nxt = 1'b1;
            end
          end else if (!dny_r) begin
            if (shb_r) begin
              regs_nxt[i2cm_pkg::IX_DR] = {8'd0, rsh_r};
              shb_nxt = 1'b0;
              regs_nxt[i2cm_pkg::IX_SR1] = regs_r[i2cm_pkg::IX_SR1]
                & ~(i2cm_pkg::M_RXNE | i2cm_pkg::M_BTF);
            end else regs_nxt[i2cm_pkg::IX_DR] = 16'd0;
          end
        end
        dny_nxt = 1'b0;
        prev_nxt = q_cmd.idx;
        res_nxt.read_data = regs_nxt[i2cm_pkg::IX_DR];
      end
      i2cm_pkg::K_RDREG: begin
        if (q_cmd.idx == i2cm_pkg::IX_SR2 && prev_r == i2cm_pkg::IX_SR1)
          regs_nxt[i2cm_pkg::IX_SR1] = regs_r[i2cm_pkg::IX_SR1] & ~i2cm_pkg::M_ADDR;
        prev_nxt = q_cmd.idx;
        res_nxt.read_data = regs_nxt[q_cmd.idx];
      end
      i2cm_pkg::K_WRCR1: begin
        regs_nxt[i2cm_pkg::IX_CR1] = q_cmd.data;
        if (q_cmd.data[i2cm_pkg::B_START]) begin
          regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1] | i2cm_pkg::M_SB;
          regs_nxt[i2cm_pkg::IX_CR1][i2cm_pkg::B_START] = 1'b0;
        end
        if (q_cmd.data[i2cm_pkg::B_POS]
            && (regs_nxt[i2cm_pkg::IX_SR1] & i2cm_pkg::M_BTF) == 16'd0) begin
          dny_nxt = 1'b1;
          regs_nxt[i2cm_pkg::IX_DR] = {8'd0, rsh_r};
          rsh_nxt = tb; res_nxt.bus_recv = open_r;
          regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1] | i2cm_pkg::M_BTF;
        end
        if (q_cmd.data[i2cm_pkg::B_STOP]) begin
          if (rdt_r && !dny_nxt) begin
            regs_nxt[i2cm_pkg::IX_DR] = {8'd0, rsh_nxt};
            rsh_nxt = tb; res_nxt.bus_recv = res_nxt.bus_recv | open_r;
            shb_nxt = 1'b1; dny_nxt = 1'b1;
          end
          open_nxt = 1'b0;
          res_nxt.bus_stop = 1'b1;
          regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1]
            & ~(i2cm_pkg::M_BTF | i2cm_pkg::M_TXE);
          regs_nxt[i2cm_pkg::IX_CR1][i2cm_pkg::B_STOP] = 1'b0;
        end
      end
      i2cm_pkg::K_WRDR: begin
        regs_nxt[i2cm_pkg::IX_DR] = q_cmd.data;
        if ((regs_r[i2cm_pkg::IX_SR1] & i2cm_pkg::M_SB) != 16'd0) begin
          regs_nxt[i2cm_pkg::IX_SR1] = (regs_r[i2cm_pkg::IX_SR1] | i2cm_pkg::M_ADDR)
            & ~i2cm_pkg::M_SB;
          tgt_nxt = q_cmd.data[7:0];
          res_nxt.bus_start = 1'b1;
          res_nxt.bus_address = q_cmd.data[7:1];
          res_nxt.bus_direction = q_cmd.data[0];
          if (q_cmd.nack) begin
            open_nxt = 1'b0;
            regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1] | i2cm_pkg::M_AF;
          end else begin
            open_nxt = 1'b1;
            rdt_nxt = q_cmd.data[0];
            if (q_cmd.data[0]) begin
              rsh_nxt = q_cmd.rx; res_nxt.bus_recv = 1'b1; shb_nxt = 1'b1;
              regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1] | i2cm_pkg::M_RXNE;
            end else
              regs_nxt[i2cm_pkg::IX_SR1] = regs_nxt[i2cm_pkg::IX_SR1] | i2cm_pkg::M_TXE;
          end
        end else if (!rdt_r && (regs_r[i2cm_pkg::IX_SR1] & i2cm_pkg::M_TXE) != 16'd0) begin
          res_nxt.bus_send = open_r;
          res_nxt.bus_tx_byte = open_r ? q_cmd.data[7:0] : 8'd0;
          regs_nxt[i2cm_pkg::IX_SR1] = regs_r[i2cm_pkg::IX_SR1] | i2cm_pkg::M_BTF;
        end
      end
      i2cm_pkg::K_WRREG: regs_nxt[q_cmd.idx] = q_cmd.data;
      default: ;
    endcase
    sr1 = regs_nxt[i2cm_pkg::IX_SR1];
    cr2 = regs_nxt[i2cm_pkg::IX_CR2];
    res_nxt.error_irq = ((cr2 & i2cm_pkg::CR2_ERREN) != 16'd0)
      && ((sr1 & i2cm_pkg::M_ERRS) != 16'd0);
    res_nxt.event_irq = ((cr2 & i2cm_pkg::CR2_EVTEN) != 16'd0)
      && (((sr1 & i2cm_pkg::M_EVT) != 16'd0)
      || (((cr2 & i2cm_pkg::CR2_BUFEN) != 16'd0) && ((sr1 & i2cm_pkg::M_BUF) != 16'd0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < i2cm_pkg::NREGS; i++)
        regs_r[i] <= (i == i2cm_pkg::IX_TRISE) ? i2cm_pkg::TRISE_RST : 16'd0;
      prev_r <= 4'd0; tgt_r <= 8'd0; rsh_r <= 8'd0;
      shb_r <= 1'b0; rdt_r <= 1'b0; dny_r <= 1'b0; open_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (go) begin
        for (int i = 0; i < i2cm_pkg::NREGS; i++) regs_r[i] <= regs_nxt[i];
        prev_r <= prev_nxt; tgt_r <= tgt_nxt; rsh_r <= rsh_nxt;
        shb_r <= shb_nxt; rdt_r <= rdt_nxt; dny_r <= dny_nxt; open_r <= open_nxt;
        ov_r <= 1'b1;
      end else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) res_r <= res_nxt;
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_send_open, (!(out_tvalid && out_res.bus_send && out_res.bus_start)),
    "send and start in one word")
  `ASSERT_NEXT(a_stall_hold, (out_tvalid && !out_tready), (out_tvalid && $stable(res_r)),
    "stalled result changed")
  `ASSERT_NEXT(a_stop_closes, (go && res_nxt.bus_stop), (!open_r), "stop left transfer open")
endmodule

[rtl/i2c_master_register_model.sv]
`timescale 1ns / 1ps
// channel | direction | tdata fields (low bit up)
// in_     | slave     | operation, reg_index, write_data, bus_rx_byte, bus_nack
// out_    | master    | read_data, event_irq, error_irq, bus_start, bus_address,
//         |           | bus_direction, bus_send, bus_tx_byte, bus_recv, bus_stop
// One word per cycle sustained while out_tready is high; each accepted input
// word is registered in the front queue and then in the back-end result register.
// The back end applies each word's register update as it takes it from the queue.
// Synchronous active-low reset clears queue, registers (TRISE to 2) and flags.
// Output stall holds the result register; with the two-entry queue behind it,
// three words are held before in_tready drops.
module i2c_master_register_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation, reg_index, write_data, bus_rx_byte, bus_nack, 2 zero pad bits
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data, event_irq, error_irq, bus_start, bus_address, bus_direction,
  // bus_send, bus_tx_byte, bus_recv, bus_stop, 2 zero pad bits
  output logic [39:0] out_tdata
);
  logic           q_valid, q_ready;
  i2cm_pkg::cmd_t q_cmd;
  i2cm_pkg::res_t r;
  logic           unused_pad;

  assign unused_pad = ^in_tdata[31:30];

  i2cm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata(in_tdata[29:0]),
    .q_valid, .q_ready, .q_cmd
  );
  i2cm_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .out_tvalid, .out_tready, .out_res(r)
  );

  // pack result word
  assign out_tdata = {2'd0, r.bus_stop, r.bus_recv, r.bus_tx_byte, r.bus_send,
                      r.bus_direction, r.bus_address, r.bus_start, r.error_irq,
                      r.event_irq, r.read_data};
endmodule
